@@ rtl/core/pfld_pkg.sv @@
// Shared types and constants for the phase-field local derivative pipeline.
`default_nettype none
package pfld_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int INTER_BITS  = 62;
    localparam int NUM_REGS    = 7;
    localparam int CFG_IDX_W   = 3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [INTER_BITS-1:0] inter_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] composition;
        logic signed [DATA_WIDTH-1:0] order_param;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] deriv_comp;
        logic signed [DATA_WIDTH-1:0] deriv_phase;
    } out_item_t;

    typedef enum logic [0:0] {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } addsub_op_t;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_ALPHA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BETA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_EQ    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BARRIER     = 3'd6;

endpackage
`default_nettype wire

@@ rtl/core/phase_field_local_derivatives.sv @@
// Top level of the phase-field local free-energy derivative pipeline.
`default_nettype none
// Streams one grid point per beat: composition c and order parameter phi in,
// dF/dc and dF/dphi out, all signed fixed point with FRAC_BITS fraction bits.
// The datapath is a 34-stage pipeline (input register, 32 arithmetic stages,
// output register), and a new beat can enter every cycle unless the output
// register holds a stalled beat and the whole pipeline is frozen. Each
// multiply is a three-stage unit (magnitude, four half-width partial products,
// round and clamp), each add or subtract one registered stage, and the
// longest chain is the dF/dphi beta term (five dependent multiplies after h').
// Stall moves the whole pipeline as one: it freezes only while the output
// register holds a beat that the receiver stalls, so nothing is dropped or
// repeated and bubbles stay in place. Intermediates are 62 bits, saturate on
// every add and multiply, and the outputs saturate to 32 bits. Write the
// seven coefficient registers only while the pipeline is empty.
module phase_field_local_derivatives
    import pfld_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_item_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire data_t                cfg_data
);

    localparam int LAST_STAGE = 32;
    localparam inter_t ONE = inter_t'(1) <<< FRAC_BITS;
    localparam inter_t K2  = inter_t'(2) <<< FRAC_BITS;
    localparam inter_t K4  = inter_t'(4) <<< FRAC_BITS;
    localparam inter_t K6  = inter_t'(6) <<< FRAC_BITS;
    localparam inter_t K10 = inter_t'(10) <<< FRAC_BITS;
    localparam inter_t K15 = inter_t'(15) <<< FRAC_BITS;
    localparam inter_t K30 = inter_t'(30) <<< FRAC_BITS;
    localparam inter_t ZERO = '0;

    // ---------------- configuration ----------------
    data_t coef_alpha_reg, coef_beta_reg, alpha_eq_reg, beta_low_reg;
    data_t beta_high_reg, coupling_reg, barrier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_alpha_reg <= '0;
            coef_beta_reg  <= '0;
            alpha_eq_reg   <= '0;
            beta_low_reg   <= '0;
            beta_high_reg  <= '0;
            coupling_reg   <= '0;
            barrier_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_ALPHA: coef_alpha_reg <= cfg_data;
                REG_COEF_BETA:  coef_beta_reg  <= cfg_data;
                REG_ALPHA_EQ:   alpha_eq_reg   <= cfg_data;
                REG_BETA_LOW:   beta_low_reg   <= cfg_data;
                REG_BETA_HIGH:  beta_high_reg  <= cfg_data;
                REG_COUPLING:   coupling_reg   <= cfg_data;
                REG_BARRIER:    barrier_reg    <= cfg_data;
                default: ;      // indexes past the list are dropped
            endcase
        end
    end

    inter_t ca, cb1, cb2, coef_a, coef_b, chi, bar_p;
    assign coef_a = inter_t'(coef_alpha_reg);
    assign coef_b = inter_t'(coef_beta_reg);
    assign ca     = inter_t'(alpha_eq_reg);
    assign cb1    = inter_t'(beta_low_reg);
    assign cb2    = inter_t'(beta_high_reg);
    assign chi    = inter_t'(coupling_reg);
    assign bar_p  = inter_t'(barrier_reg);

    // ---------------- handshake and stage valids ----------------
    logic            en;
    logic [LAST_STAGE:0] vld_reg;
    logic            out_valid_reg;
    in_item_t        in_reg;
    out_item_t       out_reg, out_next;

    // Advance everything unless the output holds a stalled beat.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAST_STAGE-1:0], in_valid};
            out_valid_reg <= vld_reg[LAST_STAGE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg  <= in_data;
            out_reg <= out_next;
        end
    end

    inter_t c0, p0;
    assign c0 = inter_t'(in_reg.composition);
    assign p0 = inter_t'(in_reg.order_param);

    // Range flags of phi: bit 1 above one, bit 0 below zero.
    logic [1:0] fl_t0, fl_t7, fl_t10, fl_t14;
    assign fl_t0 = {p0 > ONE, p0 < ZERO};

    pfld_delay #(.WIDTH(2), .DEPTH(7))  u_fl7  (.clk, .en, .d(fl_t0), .q(fl_t7));
    pfld_delay #(.WIDTH(2), .DEPTH(10)) u_fl10 (.clk, .en, .d(fl_t0), .q(fl_t10));
    pfld_delay #(.WIDTH(2), .DEPTH(14)) u_fl14 (.clk, .en, .d(fl_t0), .q(fl_t14));

    // ---------------- phi polynomials ----------------
    // Suffix _tN: value of the beat that sits in stage N.
    inter_t p2_t3, k15p_t3, k2p_t3, q_t1, qq_t4, p_t3, p3_t6, k6p2_t6, p_t6;
    inter_t p4_t9, k2p3_t9, k4p3_t9, a1_t4, a1_t6, hb_t7, p3_t7, h_t10;
    inter_t p2_t9, b1_t10, p4_t10, b2_t11, hp_t14, p2_t4, g_t7;
    inter_t k2p_t6, gp1_t7, gp1_t9, gp_t10;

    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_p2   (.clk, .en, .a(p0),    .b(p0),    .y(p2_t3));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_k15p (.clk, .en, .a(K15),   .b(p0),    .y(k15p_t3));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_k2p  (.clk, .en, .a(K2),    .b(p0),    .y(k2p_t3));
    pfld_sadd u_q (.clk, .en, .op(OP_SUB), .a(ONE), .b(p0), .y(q_t1));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_qq   (.clk, .en, .a(q_t1),  .b(q_t1),  .y(qq_t4));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(3)) u_p_d3 (.clk, .en, .d(p0), .q(p_t3));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_p3   (.clk, .en, .a(p2_t3), .b(p_t3),  .y(p3_t6));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_k6p2 (.clk, .en, .a(K6),    .b(p2_t3), .y(k6p2_t6));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(6)) u_p_d6 (.clk, .en, .d(p0), .q(p_t6));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_p4   (.clk, .en, .a(p3_t6), .b(p_t6),  .y(p4_t9));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_k2p3 (.clk, .en, .a(K2),    .b(p3_t6), .y(k2p3_t9));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_k4p3 (.clk, .en, .a(K4),    .b(p3_t6), .y(k4p3_t9));

    // h = p3 * (10 - 15p + 6p2)
    pfld_sadd u_a1 (.clk, .en, .op(OP_SUB), .a(K10), .b(k15p_t3), .y(a1_t4));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(2)) u_a1_d (.clk, .en, .d(a1_t4), .q(a1_t6));
    pfld_sadd u_hb (.clk, .en, .op(OP_ADD), .a(a1_t6), .b(k6p2_t6), .y(hb_t7));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(1)) u_p3_d (.clk, .en, .d(p3_t6), .q(p3_t7));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_h (.clk, .en, .a(p3_t7), .b(hb_t7), .y(h_t10));

    // h' = 30 * (p2 - 2p3 + p4)
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(6)) u_p2_d6 (.clk, .en, .d(p2_t3), .q(p2_t9));
    pfld_sadd u_b1 (.clk, .en, .op(OP_SUB), .a(p2_t9), .b(k2p3_t9), .y(b1_t10));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(1)) u_p4_d (.clk, .en, .d(p4_t9), .q(p4_t10));
    pfld_sadd u_b2 (.clk, .en, .op(OP_ADD), .a(b1_t10), .b(p4_t10), .y(b2_t11));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_hp (.clk, .en, .a(K30), .b(b2_t11), .y(hp_t14));

    // g = p2 * (1-p)^2
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(1)) u_p2_d1 (.clk, .en, .d(p2_t3), .q(p2_t4));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_g (.clk, .en, .a(p2_t4), .b(qq_t4), .y(g_t7));

    // g' = 2p - 6p2 + 4p3
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(3)) u_k2p_d (.clk, .en, .d(k2p_t3), .q(k2p_t6));
    pfld_sadd u_gp1 (.clk, .en, .op(OP_SUB), .a(k2p_t6), .b(k6p2_t6), .y(gp1_t7));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(2)) u_gp1_d (.clk, .en, .d(gp1_t7), .q(gp1_t9));
    pfld_sadd u_gp (.clk, .en, .op(OP_ADD), .a(gp1_t9), .b(k4p3_t9), .y(gp_t10));

    // Force the shape functions outside the unit interval.
    inter_t gsel_reg, hsel_reg, gpsel_reg, hpsel_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gsel_reg  <= (fl_t7[1] || fl_t7[0])   ? ZERO : g_t7;
            gpsel_reg <= (fl_t10[1] || fl_t10[0]) ? ZERO : gp_t10;
            hpsel_reg <= (fl_t14[1] || fl_t14[0]) ? ZERO : hp_t14;
            if (fl_t10[1])
                hsel_reg <= ONE;
            else if (fl_t10[0])
                hsel_reg <= ZERO;
            else
                hsel_reg <= h_t10;
        end
    end

    // ---------------- composition terms ----------------
    inter_t da_t1, d1_t1, d2_t1, k2c_t3, s1_t4, s_t5;
    inter_t ka_t3, kb_t3, chip_t3, x1_t3, x2_t4, x3_t7;

    pfld_sadd u_da (.clk, .en, .op(OP_SUB), .a(c0), .b(ca),  .y(da_t1));
    pfld_sadd u_d1 (.clk, .en, .op(OP_SUB), .a(c0), .b(cb1), .y(d1_t1));
    pfld_sadd u_d2 (.clk, .en, .op(OP_SUB), .a(c0), .b(cb2), .y(d2_t1));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_k2c (.clk, .en, .a(K2), .b(c0), .y(k2c_t3));
    pfld_sadd u_s1 (.clk, .en, .op(OP_SUB), .a(k2c_t3), .b(cb1), .y(s1_t4));
    pfld_sadd u_s  (.clk, .en, .op(OP_SUB), .a(s1_t4),  .b(cb2), .y(s_t5));

    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_ka   (.clk, .en, .a(K2),  .b(coef_a), .y(ka_t3));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_kb   (.clk, .en, .a(K2),  .b(coef_b), .y(kb_t3));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_chip (.clk, .en, .a(chi), .b(bar_p),  .y(chip_t3));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_x1   (.clk, .en, .a(chi), .b(c0),     .y(x1_t3));
    pfld_sadd u_x2 (.clk, .en, .op(OP_SUB), .a(ONE), .b(x1_t3), .y(x2_t4));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_x3 (.clk, .en, .a(x2_t4), .b(bar_p), .y(x3_t7));

    // ---------------- dF/dc ----------------
    inter_t omh_t12, ka_t12, m1_t15, da_t15, t1_t18;
    inter_t kb_t11, n1_t14, d1_t14, n2_t17, d2_t17, n3_t20, s_t20, t2_t23;
    inter_t chip_t8, t3_t11, t1_t23, e1_t24, t3_t24, dc_t25, dc_t32;

    // t1 = 2A (1-h) (c-ca)
    pfld_sadd u_omh (.clk, .en, .op(OP_SUB), .a(ONE), .b(hsel_reg), .y(omh_t12));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(9))  u_ka_d  (.clk, .en, .d(ka_t3), .q(ka_t12));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.clk, .en, .a(ka_t12), .b(omh_t12), .y(m1_t15));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(14)) u_da_d14 (.clk, .en, .d(da_t1), .q(da_t15));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_t1 (.clk, .en, .a(m1_t15), .b(da_t15), .y(t1_t18));

    // t2 = 2B h (c-cb1) (c-cb2) (2c-cb1-cb2)
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(8))  u_kb_d  (.clk, .en, .d(kb_t3), .q(kb_t11));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_n1 (.clk, .en, .a(kb_t11), .b(hsel_reg), .y(n1_t14));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(13)) u_d1_d13 (.clk, .en, .d(d1_t1), .q(d1_t14));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_n2 (.clk, .en, .a(n1_t14), .b(d1_t14), .y(n2_t17));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(16)) u_d2_d16 (.clk, .en, .d(d2_t1), .q(d2_t17));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_n3 (.clk, .en, .a(n2_t17), .b(d2_t17), .y(n3_t20));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(15)) u_s_d   (.clk, .en, .d(s_t5), .q(s_t20));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_t2 (.clk, .en, .a(n3_t20), .b(s_t20), .y(t2_t23));

    // t3 = chi P g
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(5)) u_chip_d (.clk, .en, .d(chip_t3), .q(chip_t8));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_t3 (.clk, .en, .a(chip_t8), .b(gsel_reg), .y(t3_t11));

    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(5))  u_t1_d (.clk, .en, .d(t1_t18), .q(t1_t23));
    pfld_sadd u_e1 (.clk, .en, .op(OP_ADD), .a(t1_t23), .b(t2_t23), .y(e1_t24));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(13)) u_t3_d (.clk, .en, .d(t3_t11), .q(t3_t24));
    pfld_sadd u_dc (.clk, .en, .op(OP_SUB), .a(e1_t24), .b(t3_t24), .y(dc_t25));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(7))  u_dc_d (.clk, .en, .d(dc_t25), .q(dc_t32));

    // ---------------- dF/dphi ----------------
    inter_t v1_t18, da_t18, v2_t21, da_t21, u1_t24, nu1_t25, nu1_t30;
    inter_t w1_t18, d1_t18, w2_t21, d1_t21, w3_t24, d2_t24, w4_t27, d2_t27, u2_t30;
    inter_t x3_t11, u3_t14, u3_t31, y1_t31, dp_t32;

    // u1 = h' A (c-ca)^2
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_v1 (.clk, .en, .a(hpsel_reg), .b(coef_a), .y(v1_t18));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(17)) u_da_d17 (.clk, .en, .d(da_t1), .q(da_t18));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_v2 (.clk, .en, .a(v1_t18), .b(da_t18), .y(v2_t21));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(20)) u_da_d20 (.clk, .en, .d(da_t1), .q(da_t21));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_u1 (.clk, .en, .a(v2_t21), .b(da_t21), .y(u1_t24));
    pfld_sadd u_nu1 (.clk, .en, .op(OP_SUB), .a(ZERO), .b(u1_t24), .y(nu1_t25));

    // u2 = h' B (c-cb1)^2 (c-cb2)^2
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_w1 (.clk, .en, .a(hpsel_reg), .b(coef_b), .y(w1_t18));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(17)) u_d1_d17 (.clk, .en, .d(d1_t1), .q(d1_t18));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_w2 (.clk, .en, .a(w1_t18), .b(d1_t18), .y(w2_t21));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(20)) u_d1_d20 (.clk, .en, .d(d1_t1), .q(d1_t21));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_w3 (.clk, .en, .a(w2_t21), .b(d1_t21), .y(w3_t24));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(23)) u_d2_d23 (.clk, .en, .d(d2_t1), .q(d2_t24));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_w4 (.clk, .en, .a(w3_t24), .b(d2_t24), .y(w4_t27));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(26)) u_d2_d26 (.clk, .en, .d(d2_t1), .q(d2_t27));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_u2 (.clk, .en, .a(w4_t27), .b(d2_t27), .y(u2_t30));

    // u3 = (1 - chi c) P g'
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(4)) u_x3_d (.clk, .en, .d(x3_t7), .q(x3_t11));
    pfld_fmul #(.FRAC_BITS(FRAC_BITS)) u_u3 (.clk, .en, .a(x3_t11), .b(gpsel_reg), .y(u3_t14));

    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(5))  u_nu1_d (.clk, .en, .d(nu1_t25), .q(nu1_t30));
    pfld_sadd u_y1 (.clk, .en, .op(OP_ADD), .a(nu1_t30), .b(u2_t30), .y(y1_t31));
    pfld_delay #(.WIDTH(INTER_BITS), .DEPTH(17)) u_u3_d (.clk, .en, .d(u3_t14), .q(u3_t31));
    pfld_sadd u_dp (.clk, .en, .op(OP_ADD), .a(y1_t31), .b(u3_t31), .y(dp_t32));

    // ---------------- output saturation ----------------
    function automatic data_t sat_field(input inter_t x);
        localparam inter_t FMAX = (inter_t'(1) <<< (DATA_WIDTH - 1)) - inter_t'(1);
        localparam inter_t FMIN = -FMAX - inter_t'(1);
        data_t r;
        if (x > FMAX)
            r = FMAX[DATA_WIDTH-1:0];
        else if (x < FMIN)
            r = FMIN[DATA_WIDTH-1:0];
        else
            r = x[DATA_WIDTH-1:0];
        return r;
    endfunction

    always_comb
    begin
        out_next.deriv_comp  = sat_field(dc_t32);
        out_next.deriv_phase = sat_field(dp_t32);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------- checks ----------------
    // Input is held off only behind a stalled output beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled output beat");

    // A beat leaving the last arithmetic stage lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[LAST_STAGE]) |=> out_valid)
        else $error("beat lost at output register");

    // A bubble leaving the last stage never shows as a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && !vld_reg[LAST_STAGE]) |=> !out_valid)
        else $error("result invented from a bubble");

endmodule
`default_nettype wire

@@ rtl/core/pfld_delay.sv @@
// Enabled shift line that aligns an operand with a later pipeline stage.
`default_nettype none
module pfld_delay #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] d,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule
`default_nettype wire

@@ rtl/core/pfld_fmul.sv @@
// Three-stage fixed-point multiplier: magnitude, partial products, round and saturate.
`default_nettype none
module pfld_fmul
    import pfld_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  wire logic   clk,
    input  wire logic   en,
    input  wire inter_t a,
    input  wire inter_t b,
    output inter_t      y
);

    localparam int LO = INTER_BITS / 2;
    localparam int HI = INTER_BITS - LO;
    localparam int PW = 2 * INTER_BITS;

    logic [INTER_BITS-1:0] ua_reg, ub_reg, ua_next, ub_next;
    logic                  neg_a_reg, neg_b_reg;
    logic [2*LO-1:0]       pp_ll_reg;
    logic [LO+HI-1:0]      pp_lh_reg, pp_hl_reg;
    logic [2*HI-1:0]       pp_hh_reg;
    logic [PW-1:0]         full, rnd, lim, mag;
    inter_t                y_reg, y_next;

    // Stage A: split sign and magnitude.
    always_comb
    begin
        ua_next = a[INTER_BITS-1] ? INTER_BITS'(-a) : INTER_BITS'(a);
        ub_next = b[INTER_BITS-1] ? INTER_BITS'(-b) : INTER_BITS'(b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg    <= ua_next;
            ub_reg    <= ub_next;
            neg_a_reg <= a[INTER_BITS-1] ^ b[INTER_BITS-1];
            // Stage B: four half-width partial products.
            pp_ll_reg <= ua_reg[LO-1:0] * ub_reg[LO-1:0];
            pp_lh_reg <= ua_reg[LO-1:0] * ub_reg[INTER_BITS-1:LO];
            pp_hl_reg <= ua_reg[INTER_BITS-1:LO] * ub_reg[LO-1:0];
            pp_hh_reg <= ua_reg[INTER_BITS-1:LO] * ub_reg[INTER_BITS-1:LO];
            neg_b_reg <= neg_a_reg;
            y_reg     <= y_next;
        end
    end

    // Stage C: sum, round half away from zero, clamp magnitude, restore sign.
    always_comb
    begin
        full = PW'(pp_ll_reg) + (PW'(pp_lh_reg) << LO) + (PW'(pp_hl_reg) << LO)
             + (PW'(pp_hh_reg) << (2 * LO));
        rnd  = (full + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim  = (PW'(1) << (INTER_BITS - 1)) - PW'(1) + PW'(neg_b_reg);
        mag  = (rnd > lim) ? lim : rnd;
        y_next = neg_b_reg ? -inter_t'(mag[INTER_BITS-1:0]) : inter_t'(mag[INTER_BITS-1:0]);
    end

    assign y = y_reg;

endmodule
`default_nettype wire

@@ rtl/core/pfld_sadd.sv @@
// Registered saturating add or subtract on intermediate-width values.
`default_nettype none
module pfld_sadd
    import pfld_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire addsub_op_t op,
    input  wire inter_t     a,
    input  wire inter_t     b,
    output inter_t          y
);

    logic signed [INTER_BITS:0] sum;
    inter_t                     y_reg, y_next;

    always_comb
    begin
        if (op == OP_SUB)
            sum = {a[INTER_BITS-1], a} - {b[INTER_BITS-1], b};
        else
            sum = {a[INTER_BITS-1], a} + {b[INTER_BITS-1], b};
        if (sum[INTER_BITS] != sum[INTER_BITS-1])
            y_next = sum[INTER_BITS] ? {1'b1, {(INTER_BITS-1){1'b0}}}
                                     : {1'b0, {(INTER_BITS-1){1'b1}}};
        else
            y_next = sum[INTER_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule
`default_nettype wire
